>>> rtl/albs_pkg.sv
`default_nettype none

package albs_pkg;

    // Alarm mode codes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_REAL  = 2'd1;
    localparam logic [1:0] MODE_DRILL = 2'd2;

    // Register word indexes on the configuration port
    localparam logic [1:0] REG_LAMP_PERIOD    = 2'd0;
    localparam logic [1:0] REG_BUZZER_PERIOD  = 2'd1;
    localparam logic [1:0] REG_REPORT_HOLDOFF = 2'd2;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [7:0] LAMP_PERIOD_RST    = 8'd20;
    localparam logic [7:0] BUZZER_PERIOD_RST  = 8'd30;
    localparam logic [7:0] REPORT_HOLDOFF_RST = 8'd50;

    // Melody lengths and notes
    localparam logic [2:0] REAL_STEPS  = 3'd2;
    localparam logic [2:0] DRILL_STEPS = 3'd5;
    localparam logic [3:0] NOTE_SILENT = 4'd0;
    localparam logic [3:0] NOTE_SOL    = 4'd5;
    localparam logic [3:0] NOTE_SI     = 4'd7;

    typedef struct packed {
        logic [1:0]  alarm_mode;
        logic [6:0]  temperature;
        logic [10:0] co2_level;
    } albs_in_t;

    typedef struct packed {
        logic [3:0]  lamp_pattern;
        logic [3:0]  tone_index;
        logic [7:0]  tone_reload;
        logic        report_temp;
        logic        report_co2;
        logic        report_alarm;
        logic [6:0]  reported_temp;
        logic [10:0] reported_co2;
        logic [1:0]  reported_alarm;
    } albs_out_t;

    // Tone timer reload per note; codes above the scale fall back to silent
    function automatic logic [7:0] tone_reload_lut(input logic [3:0] note);
        logic [7:0] val;
        unique case (note)
            4'd0:    val = 8'd1;
            4'd1:    val = 8'd17;
            4'd2:    val = 8'd43;
            4'd3:    val = 8'd66;
            4'd4:    val = 8'd77;
            4'd5:    val = 8'd97;
            4'd6:    val = 8'd114;
            4'd7:    val = 8'd117;
            4'd8:    val = 8'd137;
            default: val = 8'd1;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> rtl/alarm_lamp_buzzer_sequencer.sv
`default_nettype none

// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+----------------------------------
// in        | input     | in_valid / in_stall  | albs_in_t: mode, temp, CO2
// out       | output    | out_valid / out_stall| albs_out_t: lamps, tone, reports
// apb       | input     | psel/penable/pready  | three 8-bit registers at 0x0..0x8
//
// One tick per clock while the output is not stalled: a transfer lands in the input register
// and is written to the result register once that register is empty or being taken. The
// state advances when the input register moves into the result register. A stalled result
// holds; the input register still takes one more tick, after which in_stall follows
// out_stall. Reset clears the valid flags and all tick state and restores the register
// defaults; no clearing pass is needed.
module alarm_lamp_buzzer_sequencer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire albs_pkg::albs_in_t         in_data,
    output      logic                       out_valid,
    input  wire logic                       out_stall,
    output      albs_pkg::albs_out_t        out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [albs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [albs_pkg::PDATA_W-1:0] pwdata,
    output      logic [albs_pkg::PDATA_W-1:0] prdata,
    output      logic                       pready
);
    import albs_pkg::*;

    // Configuration registers
    logic [7:0] lamp_period_reg;
    logic [7:0] buzzer_period_reg;
    logic [7:0] report_holdoff_reg;
    logic       cfg_write;
    logic [1:0] cfg_word;

    // Pipeline registers
    logic       s1_valid_reg;
    albs_in_t   s1_data_reg;
    logic       out_valid_reg;
    albs_out_t  out_data_reg;
    logic       advance;

    // Tick state
    logic [3:0]  lamp_nibble_reg,   lamp_nibble_next;
    logic [7:0]  lamp_count_reg,    lamp_count_next;
    logic [7:0]  buzzer_count_reg,  buzzer_count_next;
    logic [2:0]  melody_step_reg,   melody_step_next;
    logic [7:0]  holdoff_count_reg, holdoff_count_next;
    logic [6:0]  last_temp_reg,     last_temp_next;
    logic [10:0] last_co2_reg,      last_co2_next;
    logic [1:0]  last_alarm_reg,    last_alarm_next;
    albs_out_t   result_next;

    // ------------------------------------------------------------------
    // APB register file: always ready, word decoded
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_word  = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_period_reg    <= LAMP_PERIOD_RST;
            buzzer_period_reg  <= BUZZER_PERIOD_RST;
            report_holdoff_reg <= REPORT_HOLDOFF_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_word)
                REG_LAMP_PERIOD:    lamp_period_reg    <= pwdata[7:0];
                REG_BUZZER_PERIOD:  buzzer_period_reg  <= pwdata[7:0];
                REG_REPORT_HOLDOFF: report_holdoff_reg <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_word)
            REG_LAMP_PERIOD:    prdata = {{(PDATA_W-8){1'b0}}, lamp_period_reg};
            REG_BUZZER_PERIOD:  prdata = {{(PDATA_W-8){1'b0}}, buzzer_period_reg};
            REG_REPORT_HOLDOFF: prdata = {{(PDATA_W-8){1'b0}}, report_holdoff_reg};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: the result register frees when empty or taken this cycle
    // ------------------------------------------------------------------
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Tick logic
    // ------------------------------------------------------------------
    always_comb
    begin
        logic       is_real;
        logic [8:0] lamp_inc;
        logic [8:0] buzz_inc;
        logic [2:0] step_inc;
        logic [2:0] step_lim;
        logic [3:0] tone;
        logic       rt;
        logic       rc;
        logic       ra;

        lamp_nibble_next   = lamp_nibble_reg;
        lamp_count_next    = lamp_count_reg;
        buzzer_count_next  = buzzer_count_reg;
        melody_step_next   = melody_step_reg;
        holdoff_count_next = holdoff_count_reg;
        last_temp_next     = last_temp_reg;
        last_co2_next      = last_co2_reg;
        last_alarm_next    = last_alarm_reg;
        tone               = NOTE_SILENT;
        rt                 = 1'b0;
        rc                 = 1'b0;
        ra                 = 1'b0;

        // Mode three behaves as the drill
        is_real  = (s1_data_reg.alarm_mode == MODE_REAL);
        lamp_inc = {1'b0, lamp_count_reg} + 9'd1;
        buzz_inc = {1'b0, buzzer_count_reg} + 9'd1;
        step_inc = melody_step_reg + 3'd1;
        step_lim = is_real ? REAL_STEPS : DRILL_STEPS;

        if (s1_data_reg.alarm_mode != MODE_OFF)
        begin
            // Lamp: toggle lamp 2 for the real alarm, lamp 1 for the drill
            if (lamp_inc >= {1'b0, lamp_period_reg})
            begin
                lamp_count_next  = '0;
                lamp_nibble_next = is_real ? ((lamp_nibble_reg + 4'd2) & 4'h2)
                                           : ((lamp_nibble_reg + 4'd1) & 4'h1);
            end
            else
            begin
                lamp_count_next = lamp_inc[7:0];
            end

            // Buzzer: step the melody, wrap at its length
            if (buzz_inc >= {1'b0, buzzer_period_reg})
            begin
                buzzer_count_next = '0;
                melody_step_next  = (step_inc >= step_lim) ? 3'd0 : step_inc;
            end
            else
            begin
                buzzer_count_next = buzz_inc[7:0];
            end

            if (is_real)
                tone = (melody_step_next != 3'd0) ? NOTE_SI : NOTE_SOL;
            else
                tone = (melody_step_next <= 3'd3) ? ({1'b0, melody_step_next} + 4'd1)
                                                  : NOTE_SOL;
        end
        else
        begin
            buzzer_count_next = '0;
            melody_step_next  = '0;
            lamp_nibble_next  = 4'h1;
        end

        // Rate-limited change reports
        if (holdoff_count_reg == 8'd0)
        begin
            rt = (s1_data_reg.temperature != last_temp_reg);
            rc = (s1_data_reg.co2_level   != last_co2_reg);
            ra = (s1_data_reg.alarm_mode  != last_alarm_reg);
            if (rt) last_temp_next  = s1_data_reg.temperature;
            if (rc) last_co2_next   = s1_data_reg.co2_level;
            if (ra) last_alarm_next = s1_data_reg.alarm_mode;
            if (rt || rc || ra) holdoff_count_next = report_holdoff_reg;
        end
        else
        begin
            holdoff_count_next = holdoff_count_reg - 8'd1;
        end

        result_next.lamp_pattern   = lamp_nibble_next;
        result_next.tone_index     = tone;
        result_next.tone_reload    = tone_reload_lut(tone);
        result_next.report_temp    = rt;
        result_next.report_co2     = rc;
        result_next.report_alarm   = ra;
        result_next.reported_temp  = last_temp_next;
        result_next.reported_co2   = last_co2_next;
        result_next.reported_alarm = last_alarm_next;
    end

    // ------------------------------------------------------------------
    // Control and state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            lamp_nibble_reg   <= '0;
            lamp_count_reg    <= '0;
            buzzer_count_reg  <= '0;
            melody_step_reg   <= '0;
            holdoff_count_reg <= '0;
            last_temp_reg     <= '0;
            last_co2_reg      <= '0;
            last_alarm_reg    <= '0;
        end
        else
        begin
            // Input register fills on a transfer, drains on advance
            if (in_valid && !in_stall)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                lamp_nibble_reg   <= lamp_nibble_next;
                lamp_count_reg    <= lamp_count_next;
                buzzer_count_reg  <= buzzer_count_next;
                melody_step_reg   <= melody_step_next;
                holdoff_count_reg <= holdoff_count_next;
                last_temp_reg     <= last_temp_next;
                last_co2_reg      <= last_co2_next;
                last_alarm_reg    <= last_alarm_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_data_reg <= in_data;
        if (advance)
            out_data_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_off_lights_lamp1: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_data_reg.alarm_mode == MODE_OFF)
        |=> (out_data.lamp_pattern == 4'h1 && out_data.tone_index == NOTE_SILENT))
        else $error("alarm off did not force lamp 1 and silence");

    a_report_loads_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (result_next.report_temp || result_next.report_co2
                     || result_next.report_alarm))
        |=> (holdoff_count_reg == $past(report_holdoff_reg)))
        else $error("report did not reload the holdoff counter");

    a_reload_matches_tone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.tone_reload == tone_reload_lut(out_data.tone_index)))
        else $error("tone reload does not match the note");

endmodule

`default_nettype wire

>>> test/albs_tick_checker.sv
`timescale 1ns / 100ps

module albs_tick_checker
    import albs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  albs_in_t           in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  albs_out_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 ticks_in,
    output int                 results_seen,
    output int                 mismatches
);

    // Timer reload per note, index 0 is the silent entry
    localparam logic [8:0][7:0] NOTE_RELOAD = {8'd137, 8'd117, 8'd114, 8'd97, 8'd77,
                                               8'd66, 8'd43, 8'd17, 8'd1};

    logic [7:0]  lamp_period;
    logic [7:0]  buzzer_period;
    logic [7:0]  report_holdoff;

    logic [3:0]  lamp_nibble;
    logic [7:0]  lamp_count;
    logic [7:0]  buzzer_count;
    logic [2:0]  melody_step;
    logic [7:0]  holdoff_count;
    logic [6:0]  last_temp;
    logic [10:0] last_co2;
    logic [1:0]  last_alarm;

    albs_out_t   expected_ticks[$];
    albs_out_t   want;

    // Bit 8 flags the event, bits 7:0 hold the new count
    function automatic logic [8:0] count_up(input logic [7:0] count, input logic [7:0] period);
        logic [8:0] nxt;
        nxt = {1'b0, count} + 9'd1;
        if (nxt >= {1'b0, period})
            return 9'h100;
        return nxt;
    endfunction

    function automatic albs_out_t predict_tick(input albs_in_t t);
        albs_out_t  r;
        logic [8:0] lamp_ev;
        logic [8:0] buzz_ev;
        logic [2:0] nstep;
        logic       is_real;
        logic [3:0] note;
        r    = '0;
        note = NOTE_SILENT;
        if (t.alarm_mode != MODE_OFF) begin
            // mode three falls through as a drill
            is_real    = (t.alarm_mode == MODE_REAL);
            lamp_ev    = count_up(lamp_count, lamp_period);
            lamp_count = lamp_ev[7:0];
            if (lamp_ev[8])
                lamp_nibble = is_real ? ((lamp_nibble + 4'd2) & 4'h2)
                                      : ((lamp_nibble + 4'd1) & 4'h1);
            buzz_ev      = count_up(buzzer_count, buzzer_period);
            buzzer_count = buzz_ev[7:0];
            if (buzz_ev[8]) begin
                nstep = melody_step + 3'd1;
                if (nstep >= (is_real ? REAL_STEPS : DRILL_STEPS))
                    nstep = '0;
                melody_step = nstep;
            end
            if (is_real)
                note = (melody_step != 3'd0) ? NOTE_SI : NOTE_SOL;
            else
                note = (melody_step <= 3'd3) ? {1'b0, melody_step} + 4'd1 : NOTE_SOL;
        end else begin
            buzzer_count = '0;
            melody_step  = '0;
            lamp_nibble  = 4'd1;
        end

        if (holdoff_count == 8'd0) begin
            if (t.temperature != last_temp) begin
                last_temp     = t.temperature;
                r.report_temp = 1'b1;
            end
            if (t.co2_level != last_co2) begin
                last_co2     = t.co2_level;
                r.report_co2 = 1'b1;
            end
            if (t.alarm_mode != last_alarm) begin
                last_alarm     = t.alarm_mode;
                r.report_alarm = 1'b1;
            end
            if (r.report_temp | r.report_co2 | r.report_alarm)
                holdoff_count = report_holdoff;
        end else begin
            holdoff_count = holdoff_count - 8'd1;
        end

        r.lamp_pattern   = lamp_nibble;
        r.tone_index     = note;
        r.tone_reload    = NOTE_RELOAD[note];
        r.reported_temp  = last_temp;
        r.reported_co2   = last_co2;
        r.reported_alarm = last_alarm;
        return r;
    endfunction

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report($sformatf("%s got %0d, want %0d", name, got, exp_val));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lamp_period    = LAMP_PERIOD_RST;
            buzzer_period  = BUZZER_PERIOD_RST;
            report_holdoff = REPORT_HOLDOFF_RST;
            lamp_nibble    = '0;
            lamp_count     = '0;
            buzzer_count   = '0;
            melody_step    = '0;
            holdoff_count  = '0;
            last_temp      = '0;
            last_co2       = '0;
            last_alarm     = '0;
            mismatches     = 0;
            expected_ticks.delete();
            ticks_in     <= 0;
            results_seen <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_LAMP_PERIOD:    lamp_period    = pwdata[7:0];
                    REG_BUZZER_PERIOD:  buzzer_period  = pwdata[7:0];
                    REG_REPORT_HOLDOFF: report_holdoff = pwdata[7:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                expected_ticks.push_back(predict_tick(in_data));
                ticks_in <= ticks_in + 1;
            end
            if (out_valid && !out_stall) begin
                if (expected_ticks.size() == 0) begin
                    report("result with no tick pending");
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("lamp_pattern", out_data.lamp_pattern, want.lamp_pattern);
                    check_field("tone_index", out_data.tone_index, want.tone_index);
                    check_field("tone_reload", out_data.tone_reload, want.tone_reload);
                    check_field("report_temp", out_data.report_temp, want.report_temp);
                    check_field("report_co2", out_data.report_co2, want.report_co2);
                    check_field("report_alarm", out_data.report_alarm, want.report_alarm);
                    check_field("reported_temp", out_data.reported_temp, want.reported_temp);
                    check_field("reported_co2", out_data.reported_co2, want.reported_co2);
                    check_field("reported_alarm", out_data.reported_alarm,
                                want.reported_alarm);
                end
                results_seen <= results_seen + 1;
            end
        end
    end

endmodule

>>> test/alarm_lamp_buzzer_sequencer_tb.sv
`timescale 1ns / 100ps

module alarm_lamp_buzzer_sequencer_tb;
    import albs_pkg::*;

    // Mode three has no name in the package; the block treats it as a drill
    localparam logic [1:0] MODE_ALIAS = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    albs_in_t           in_data   = '0;
    logic               out_stall = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;

    logic               in_stall;
    logic               out_valid;
    albs_out_t          out_data;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int ticks_in;
    int results_seen;
    int mismatches;

    // Scene state for the random part: an alarm holds for a run of ticks while
    // the sensor readings drift slowly
    logic               quiet = 1'b0;
    int                 settings_used;
    int                 run_left;
    int                 pick;
    logic [1:0]         mode_now;
    logic [6:0]         temp_now;
    logic [10:0]        co2_now;
    logic [7:0]         lp;
    logic [7:0]         bp;
    logic [7:0]         hp;

    alarm_lamp_buzzer_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    albs_tick_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .ticks_in     (ticks_in),
        .results_seen (results_seen),
        .mismatches   (mismatches)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver side: stall at random with odds of 19 in 100, never during the quiet phase
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 19);
    end

    // Offer one tick, after random idles outside the quiet phase, and hold it until the
    // transfer happens. Valid stays high on exit; it drops between ticks only for those idles and in drain.
    task automatic send_tick(input logic [1:0] mode, input logic [6:0] temp,
                             input logic [10:0] co2);
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < 19)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid            <= 1'b1;
        in_data.alarm_mode  <= mode;
        in_data.temperature <= temp;
        in_data.co2_level   <= co2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every tick sent so far has come back
    task automatic drain;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_seen < ticks_in);
    endtask

    // Setup then access; psel stays high so that writes can follow back to back
    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // Reprogram all three registers with the block idle
    task automatic apply_setting(input logic [7:0] lamp, input logic [7:0] buzz,
                                 input logic [7:0] hold);
        drain();
        write_reg(REG_LAMP_PERIOD, lamp);
        write_reg(REG_BUZZER_PERIOD, buzz);
        write_reg(REG_REPORT_HOLDOFF, hold);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        settings_used = 1;
        run_left      = 0;
        mode_now      = MODE_OFF;
        temp_now      = '0;
        co2_now       = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: nothing changed, then every field changes at once,
        // then changes masked by the holdoff, then mode three
        send_tick(MODE_OFF, 7'd0, 11'd0);
        send_tick(MODE_REAL, 7'd127, 11'd2047);
        send_tick(MODE_DRILL, 7'd0, 11'd0);
        send_tick(MODE_ALIAS, 7'd64, 11'd1024);

        // Every tick steps: walk the drill up to its last note, then switch to the real alarm so
        // the large step wraps; holdoff is set to zero, but the count loaded earlier still masks reports
        apply_setting(8'd1, 8'd1, 8'd0);
        send_tick(MODE_DRILL, 7'd5, 11'd100);
        send_tick(MODE_DRILL, 7'd5, 11'd100);
        send_tick(MODE_DRILL, 7'd6, 11'd101);
        send_tick(MODE_ALIAS, 7'd6, 11'd101);
        send_tick(MODE_REAL, 7'd7, 11'd2000);
        send_tick(MODE_REAL, 7'd7, 11'd2000);
        send_tick(MODE_REAL, 7'd100, 11'd2000);
        send_tick(MODE_OFF, 7'd100, 11'd0);
        send_tick(MODE_OFF, 7'd100, 11'd0);
        send_tick(MODE_DRILL, 7'd1, 11'd1);

        // Zero periods fire on every alarm tick
        apply_setting(8'd0, 8'd0, 8'd0);
        send_tick(MODE_REAL, 7'd0, 11'd2047);
        send_tick(MODE_DRILL, 7'd127, 11'd0);
        send_tick(MODE_REAL, 7'd0, 11'd0);
        send_tick(MODE_OFF, 7'd1, 11'd1);
        send_tick(MODE_ALIAS, 7'd2, 11'd2);

        // Full-scale periods and holdoff
        apply_setting(8'd255, 8'd255, 8'd255);
        send_tick(MODE_REAL, 7'd127, 11'd2047);
        send_tick(MODE_REAL, 7'd0, 11'd0);
        send_tick(MODE_OFF, 7'd127, 11'd0);

        // Random phases: mostly alarms that persist for a while with drifting
        // readings, a sprinkle of fully random ticks as noise
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin lp = 8'd2; bp = 8'd3; hp = 8'd1; end
                1: begin lp = 8'd255; bp = 8'd255; hp = 8'd255; end
                2: begin lp = 8'd0; bp = 8'd0; hp = 8'd0; end
                3: begin lp = 8'd4; bp = 8'd6; hp = 8'd8; end
                default:
                begin
                    lp = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 12));
                    bp = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 12));
                    hp = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 20));
                end
            endcase
            apply_setting(lp, bp, hp);
            // hold off idling on both sides for one whole phase
            quiet <= (p == 3);

            repeat (235)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_tick(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                              11'($urandom_range(0, 2047)));
                end
                else
                begin
                    if (run_left == 0)
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 3)
                            mode_now = MODE_OFF;
                        else if (pick < 6)
                            mode_now = MODE_REAL;
                        else if (pick < 9)
                            mode_now = MODE_DRILL;
                        else
                            mode_now = MODE_ALIAS;
                        run_left = $urandom_range(1, 60);
                    end
                    run_left--;

                    pick = $urandom_range(0, 99);
                    if (pick >= 95)
                        temp_now = 7'($urandom_range(0, 127));
                    else if (pick >= 75)
                        temp_now = temp_now - 7'd1;
                    else if (pick >= 55)
                        temp_now = temp_now + 7'd1;

                    pick = $urandom_range(0, 99);
                    if (pick >= 90)
                        co2_now = 11'($urandom_range(0, 2047));
                    else if (pick >= 50)
                        co2_now = co2_now + 11'($urandom_range(0, 40)) - 11'd20;

                    send_tick(mode_now, temp_now, co2_now);
                end
            end
        end

        // Let the last results out, then wait on to catch any stray ones
        drain();
        repeat (4) @(posedge clk);

        $display("covered %0d ticks over %0d register settings, %0d results compared",
                 ticks_in, settings_used, results_seen);
        $display("modes off, real, drill and three; zero, unit and full-scale periods");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Give up well past the slowest correct run
    initial
    begin
        #2000000;
        $display("timeout waiting for results");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> alarm_lamp_buzzer_sequencer.f
rtl/albs_pkg.sv
rtl/alarm_lamp_buzzer_sequencer.sv
test/albs_tick_checker.sv
test/alarm_lamp_buzzer_sequencer_tb.sv
